>>> hdl/huffman_tree_bit_decoder_macros.svh
// Assertion macros shared by the decoder RTL.
// Needs clk and arst_n in scope at the point of use.
`ifndef HUFFMAN_TREE_BIT_DECODER_MACROS_SVH
`define HUFFMAN_TREE_BIT_DECODER_MACROS_SVH

// property that must hold at every edge outside reset
`define HBD_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// cond in one cycle implies nxt in the following cycle
`define HBD_CHECK_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) cond |=> nxt) else $error(msg);

`endif

>>> hdl/hbd_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies.
package hbd_pkg;

	localparam int BYTE_BITS = 8;
	localparam int KEY_LIMIT = 64;

	// one tree table entry, left child in the lowest bits
	typedef struct packed {
		logic [7:0] symbol;
		logic       has_right;
		logic       has_left;
		logic [8:0] right;
		logic [8:0] left;
	} node_t;

	typedef enum logic [1:0] {
		REQ_NODE = 2'd0,
		REQ_KEY  = 2'd1,
		REQ_DATA = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		CFG_ROOT   = 2'd0,
		CFG_KEYLEN = 2'd1,
		CFG_PAD    = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_MIDCODE = 2'd2
	} status_t;

	typedef enum logic {
		KIND_SYMBOL = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	// outcome of one walk step
	typedef struct packed {
		logic       leaf;
		logic       has;
		logic [8:0] child;
	} step_t;

endpackage

>>> hdl/hbd_tree_ram.sv
// Tree node table: one write port, two registered read ports.
// Uses hbd_pkg::node_t.
module hbd_tree_ram #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  hbd_pkg::node_t     wdata,
	input  logic               re_a,
	input  logic [AW-1:0]      raddr_a,
	output hbd_pkg::node_t     rdata_a,
	input  logic [AW-1:0]      raddr_b,
	output hbd_pkg::node_t     rdata_b
);

	hbd_pkg::node_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
	end

	// port b follows the root index every cycle
	always_ff @(posedge clk) begin
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> hdl/hbd_key_ram.sv
// Key byte table: one write port, one registered read port.
// No package dependencies.
module hbd_key_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/hbd_walk_unit.sv
// Shared walk step: leaf check of a fetched child, then child select for one bit.
// Uses hbd_pkg::node_t and hbd_pkg::step_t.
module hbd_walk_unit (
	input  hbd_pkg::node_t rd_a,
	input  hbd_pkg::node_t rd_b,
	input  logic           cur_root,
	input  logic           chk,
	input  logic           bit_in,
	output hbd_pkg::step_t step
);

	hbd_pkg::node_t cur;

	always_comb begin
		// a fetched child that is not a leaf becomes the current node at once
		cur        = (cur_root && !chk) ? rd_b : rd_a;
		step.leaf  = chk && !(rd_a.has_left || rd_a.has_right);
		step.has   = bit_in ? cur.has_right : cur.has_left;
		step.child = bit_in ? cur.right : cur.left;
	end

endmodule

>>> hdl/huffman_tree_bit_decoder.sv
// Huffman tree-walk decoder. Node and key loads are written as they are accepted.
// A data byte reads its walk node and key byte as it is accepted, has the key applied in PREP,
// then walks its bits in WALK, with an extra step for each symbol found and a closing step,
// and FLUSH releases the last result; a stalled output holds the walk and the release.
// Reset clears all control state and the registers; the tables are not cleared.
`include "huffman_tree_bit_decoder_macros.svh"

module huffman_tree_bit_decoder #(
	parameter int TREE_NODES = 512,
	parameter int KEY_DEPTH  = 64
) (
	input  logic        clk,
	input  logic        arst_n,

	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [8:0] node_index, [17:9] left_child, [26:18] right_child, [27] has_left,
	// [28] has_right, [36:29] node_symbol, [42:37] key_index, [50:43] key_value,
	// [58:51] data_byte, [63:59] zero
	input  logic [63:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
	input  logic        s_axis_tlast,   // last_byte

	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_symbol, [9:8] status, [15:10] zero
	output logic        m_axis_tuser,   // [0] out_kind
	output logic        m_axis_tlast,   // last_result

	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int TAW    = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;
	localparam int KAW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int KL_MAX = (KEY_DEPTH < hbd_pkg::KEY_LIMIT) ? KEY_DEPTH : hbd_pkg::KEY_LIMIT;

	// IDLE takes items, PREP applies the key, WALK steps bits, FLUSH closes the byte
	typedef enum logic [1:0] {IDLE, PREP, WALK, FLUSH} state_t;

	state_t           state_q;
	logic [8:0]       root_q;
	logic [6:0]       keylen_q;
	logic [2:0]       pad_q;
	logic [8:0]       walk_q;
	logic [5:0]       kp_q;
	logic             err_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic [3:0]       bits_q;
	logic             kuse_q;
	logic             cur_root_q;
	logic             chk_q;
	logic [8:0]       child_q;
	logic             oob_a_q;
	// held result: released once it is known whether another follows
	logic             pend_v_q;
	hbd_pkg::kind_t   pend_kind_q;
	logic [7:0]       pend_sym_q;
	hbd_pkg::status_t pend_st_q;
	// output register
	logic             m_valid_q;
	hbd_pkg::kind_t   m_kind_q;
	logic [7:0]       m_sym_q;
	hbd_pkg::status_t m_st_q;
	logic             m_last_q;

	// input fields
	logic [8:0] node_index, left_child, right_child;
	logic       has_left, has_right;
	logic [7:0] node_symbol, key_value, data_byte;
	logic [5:0] key_index;

	assign node_index  = s_axis_tdata[8:0];
	assign left_child  = s_axis_tdata[17:9];
	assign right_child = s_axis_tdata[26:18];
	assign has_left    = s_axis_tdata[27];
	assign has_right   = s_axis_tdata[28];
	assign node_symbol = s_axis_tdata[36:29];
	assign key_index   = s_axis_tdata[42:37];
	assign key_value   = s_axis_tdata[50:43];
	assign data_byte   = s_axis_tdata[58:51];

	logic           s_acc, data_acc, start;
	logic           tree_we, key_we;
	hbd_pkg::node_t node_wr;
	logic [6:0]     len_eff;
	logic [5:0]     kp_eff, kp_next;
	logic [6:0]     kp_inc;
	logic [3:0]     nbits;
	logic           out_free, go, leaf_hit, adv, done, miss, issue;
	logic           m_load;
	logic [8:0]     walk_eff;
	logic           re_a, oob_a_next;
	logic [TAW-1:0] raddr_a;
	logic           root_oob;
	hbd_pkg::node_t rd_a_raw, rd_b_raw, rd_a_m, rd_b_m;
	logic [7:0]     key_rd;
	hbd_pkg::step_t step;
	logic             res_v;
	hbd_pkg::kind_t   res_kind;
	logic [7:0]       res_sym;
	hbd_pkg::status_t res_st;
	logic           miss_held, at_root, bits_ok;

	assign s_axis_tready = (state_q == IDLE);
	assign cfg_ready     = 1'b1;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign data_acc      = s_acc && (s_axis_tuser == hbd_pkg::REQ_DATA);
	assign start         = data_acc && !err_q;

	assign tree_we = s_acc && (s_axis_tuser == hbd_pkg::REQ_NODE)
		&& (32'(node_index) < TREE_NODES);
	assign key_we  = s_acc && (s_axis_tuser == hbd_pkg::REQ_KEY)
		&& (32'(key_index) < KEY_DEPTH);

	always_comb begin
		node_wr.symbol    = node_symbol;
		node_wr.has_right = has_right;
		node_wr.has_left  = has_left;
		node_wr.right     = right_child;
		node_wr.left      = left_child;
	end

	// key position: wrap before use and after the increment
	assign len_eff = (32'(keylen_q) > KL_MAX) ? 7'(KL_MAX) : keylen_q;
	assign kp_eff  = ({1'b0, kp_q} >= len_eff) ? 6'd0 : kp_q;
	assign kp_inc  = {1'b0, kp_eff} + 7'd1;
	assign kp_next = (kp_inc >= len_eff) ? 6'd0 : kp_inc[5:0];

	// last byte walks (8 - pad) mod 8 bits
	assign nbits = s_axis_tlast ? {1'b0, 3'(3'd0 - pad_q)} : 4'(hbd_pkg::BYTE_BITS);

	// walk step control
	assign out_free = !m_valid_q || m_axis_tready;
	assign go       = (state_q == WALK) && out_free;
	assign leaf_hit = go && step.leaf;
	assign adv      = go && !step.leaf;
	assign done     = adv && (bits_q == 4'd0);
	assign miss     = adv && (bits_q != 4'd0) && !step.has;
	assign issue    = adv && (bits_q != 4'd0) && step.has;
	assign walk_eff = chk_q ? child_q : walk_q;

	// output register takes a pushed-out or a closing result this cycle
	assign m_load = pend_v_q && (res_v || ((state_q == FLUSH) && out_free));

	// port a fetches the walk node at byte start, then each child
	assign re_a       = start || issue;
	assign raddr_a    = (state_q == IDLE) ? TAW'(walk_q) : TAW'(step.child);
	assign oob_a_next = (state_q == IDLE) ? (32'(walk_q) >= TREE_NODES)
		: (32'(step.child) >= TREE_NODES);
	assign root_oob   = (32'(root_q) >= TREE_NODES);

	// indexes past the table read as an empty leaf with symbol zero
	assign rd_a_m = oob_a_q ? '0 : rd_a_raw;
	assign rd_b_m = root_oob ? '0 : rd_b_raw;

	hbd_tree_ram #(
		.DEPTH (TREE_NODES),
		.AW    (TAW)
	) u_tree (
		.clk     (clk),
		.we      (tree_we),
		.waddr   (TAW'(node_index)),
		.wdata   (node_wr),
		.re_a    (re_a),
		.raddr_a (raddr_a),
		.rdata_a (rd_a_raw),
		.raddr_b (TAW'(root_q)),
		.rdata_b (rd_b_raw)
	);

	hbd_key_ram #(
		.DEPTH (KEY_DEPTH),
		.AW    (KAW)
	) u_key (
		.clk   (clk),
		.we    (key_we),
		.waddr (KAW'(key_index)),
		.wdata (key_value),
		.re    (start),
		.raddr (KAW'(kp_eff)),
		.rdata (key_rd)
	);

	hbd_walk_unit u_walk (
		.rd_a     (rd_a_m),
		.rd_b     (rd_b_m),
		.cur_root (cur_root_q),
		.chk      (chk_q),
		.bit_in   (byte_q[7]),
		.step     (step)
	);

	// result made by this step, if any
	always_comb begin
		res_v    = 1'b0;
		res_kind = hbd_pkg::KIND_SYMBOL;
		res_sym  = 8'd0;
		res_st   = hbd_pkg::ST_OK;
		if (leaf_hit) begin
			res_v   = 1'b1;
			res_sym = rd_a_m.symbol;
		end else if (miss) begin
			res_v    = 1'b1;
			res_kind = hbd_pkg::KIND_STATUS;
			res_st   = hbd_pkg::ST_MISSING;
		end else if (done && last_q) begin
			res_v    = 1'b1;
			res_kind = hbd_pkg::KIND_STATUS;
			res_st   = (walk_eff == root_q) ? hbd_pkg::ST_OK : hbd_pkg::ST_MIDCODE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			root_q      <= '0;
			keylen_q    <= '0;
			pad_q       <= '0;
			walk_q      <= '0;
			kp_q        <= '0;
			err_q       <= 1'b0;
			byte_q      <= '0;
			last_q      <= 1'b0;
			bits_q      <= '0;
			kuse_q      <= 1'b0;
			cur_root_q  <= 1'b0;
			chk_q       <= 1'b0;
			child_q     <= '0;
			oob_a_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_kind_q <= hbd_pkg::KIND_SYMBOL;
			pend_sym_q  <= '0;
			pend_st_q   <= hbd_pkg::ST_OK;
			m_valid_q   <= 1'b0;
			m_kind_q    <= hbd_pkg::KIND_SYMBOL;
			m_sym_q     <= '0;
			m_st_q      <= hbd_pkg::ST_OK;
			m_last_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hbd_pkg::CFG_ROOT: begin
						root_q <= cfg_data;
						walk_q <= cfg_data;
					end
					hbd_pkg::CFG_KEYLEN: begin
						keylen_q <= cfg_data[6:0];
						kp_q     <= '0;
					end
					hbd_pkg::CFG_PAD: begin
						pad_q <= cfg_data[2:0];
					end
					default: begin
					end
				endcase
			end

			if (m_valid_q && m_axis_tready && !m_load) begin
				m_valid_q <= 1'b0;
			end

			if (re_a) begin
				oob_a_q <= oob_a_next;
			end

			// a new result pushes the held one out, which therefore is not last
			if (res_v) begin
				if (pend_v_q) begin
					m_valid_q <= 1'b1;
					m_kind_q  <= pend_kind_q;
					m_sym_q   <= pend_sym_q;
					m_st_q    <= pend_st_q;
					m_last_q  <= 1'b0;
				end
				pend_v_q    <= 1'b1;
				pend_kind_q <= res_kind;
				pend_sym_q  <= res_sym;
				pend_st_q   <= res_st;
			end

			case (state_q)
				IDLE: begin
					if (data_acc) begin
						if (err_q) begin
							// bytes after an error are dropped up to the last one
							if (s_axis_tlast) begin
								walk_q <= root_q;
								kp_q   <= '0;
								err_q  <= 1'b0;
							end
						end else begin
							byte_q  <= data_byte;
							last_q  <= s_axis_tlast;
							bits_q  <= nbits;
							kuse_q  <= (len_eff != 7'd0);
							if (len_eff != 7'd0) begin
								kp_q <= kp_next;
							end
							state_q <= PREP;
						end
					end
				end
				PREP: begin
					if (kuse_q) begin
						byte_q <= byte_q ^ key_rd;
					end
					chk_q      <= 1'b0;
					cur_root_q <= 1'b0;
					state_q    <= WALK;
				end
				WALK: begin
					if (leaf_hit) begin
						walk_q     <= root_q;
						cur_root_q <= 1'b1;
						chk_q      <= 1'b0;
					end else if (adv) begin
						if (done || miss) begin
							chk_q   <= 1'b0;
							state_q <= FLUSH;
							if (last_q) begin
								// end of stream: back to the root, error cleared
								walk_q <= root_q;
								kp_q   <= '0;
								err_q  <= 1'b0;
							end else begin
								if (chk_q) begin
									walk_q <= child_q;
								end
								if (miss) begin
									err_q <= 1'b1;
								end
							end
						end else begin
							if (chk_q) begin
								walk_q <= child_q;
							end
							child_q    <= step.child;
							chk_q      <= 1'b1;
							cur_root_q <= 1'b0;
							bits_q     <= bits_q - 4'd1;
							byte_q     <= {byte_q[6:0], 1'b0};
						end
					end
				end
				FLUSH: begin
					if (out_free) begin
						if (pend_v_q) begin
							m_valid_q <= 1'b1;
							m_kind_q  <= pend_kind_q;
							m_sym_q   <= pend_sym_q;
							m_st_q    <= pend_st_q;
							m_last_q  <= 1'b1;
							pend_v_q  <= 1'b0;
						end
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, m_st_q, m_sym_q};
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tlast  = m_last_q;

	assign miss_held = (state_q == FLUSH) && pend_v_q && (pend_st_q == hbd_pkg::ST_MISSING);
	assign at_root   = (walk_q == root_q) && cur_root_q && !chk_q;
	assign bits_ok   = (bits_q <= 4'(hbd_pkg::BYTE_BITS));

	// nothing held over and no fetch outstanding between bytes
	`HBD_CHECK(a_idle_clean, (state_q == IDLE) |-> (!pend_v_q && !chk_q), "idle not clean")
	// a missing child ends the byte with the error status held for the closing transfer
	`HBD_CHECK_NEXT(a_miss_closes, miss, miss_held, "missing child did not close the byte")
	// a leaf sends the walk back to the root
	`HBD_CHECK_NEXT(a_leaf_root, leaf_hit, at_root, "walk not back at root after leaf")
	`HBD_CHECK(a_bits_range, (state_q == WALK) |-> bits_ok, "bit count out of range")

endmodule

>>> bench/tb_huffman_tree_bit_decoder.sv
// Self-checking bench for the Huffman tree-walk decoder: random trees, keys and streams,
// with a scoreboard class that predicts every symbol and status transfer.
// Depends on hbd_pkg and the huffman_tree_bit_decoder RTL.
module tb_huffman_tree_bit_decoder;

	localparam int NODES        = 512;
	localparam int KEYS         = 64;
	localparam int TOTAL_ITEMS  = 325;      // directed opening plus the random body
	localparam int SETTLE       = 40;       // longer than the worst byte walk, plus slack
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int REPORT_LIMIT = 100;      // mismatch lines printed before going quiet

	// request code the block must ignore
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// one input transfer, field for field
	typedef struct {
		logic [1:0] req;
		logic [8:0] node_index;
		logic [8:0] left_child;
		logic [8:0] right_child;
		logic       has_left;
		logic       has_right;
		logic [7:0] node_symbol;
		logic [5:0] key_index;
		logic [7:0] key_value;
		logic [7:0] data_byte;
		logic       last_byte;
	} req_item_t;

	// one result transfer
	typedef struct {
		hbd_pkg::kind_t   kind;
		logic [7:0]       symbol;
		hbd_pkg::status_t status;
		logic             last;
	} dec_out_t;

	// Tracks the decoder state and holds the results still owed by the block.
	class decode_checker;
		hbd_pkg::node_t tree [NODES];
		logic [7:0] key_bytes [KEYS];
		logic [8:0] root_idx;
		logic [8:0] walk_idx;
		logic [6:0] key_len;
		logic [2:0] pad;
		int         key_pos;
		bit         in_error;
		dec_out_t   due [$];
		int         fails;

		function new();
			root_idx = '0;
			walk_idx = '0;
			key_len  = '0;
			pad      = '0;
			key_pos  = 0;
			in_error = 1'b0;
			fails    = 0;
		endfunction

		function int outstanding();
			return due.size();
		endfunction

		function void write_reg(hbd_pkg::cfg_reg_t idx, logic [8:0] value);
			case (idx)
				hbd_pkg::CFG_ROOT: begin
					root_idx = value;
					walk_idx = value;
				end
				hbd_pkg::CFG_KEYLEN: begin
					key_len = value[6:0];
					key_pos = 0;
				end
				hbd_pkg::CFG_PAD: pad = value[2:0];
				default: ;
			endcase
		endfunction

		function void end_stream();
			walk_idx = root_idx;
			key_pos  = 0;
			in_error = 1'b0;
		endfunction

		function void push_out(hbd_pkg::kind_t k, logic [7:0] s, hbd_pkg::status_t st);
			dec_out_t o;
			o.kind   = k;
			o.symbol = s;
			o.status = st;
			o.last   = 1'b0;
			due.push_back(o);
		endfunction

		function void walk_byte(logic [7:0] raw, logic last);
			int             span;
			int             nbits;
			int             first;
			logic [7:0]     b;
			hbd_pkg::node_t cur;
			hbd_pkg::node_t nxt;
			logic           bit_v;
			logic           has;
			logic [8:0]     child;
			first = due.size();
			span = (key_len > hbd_pkg::KEY_LIMIT) ? hbd_pkg::KEY_LIMIT : int'(key_len);
			// after a missing child the rest of the stream is swallowed
			if (in_error) begin
				if (last)
					end_stream();
				return;
			end
			b = raw;
			if (span != 0) begin
				if (key_pos >= span)
					key_pos = 0;
				b = b ^ key_bytes[key_pos];
				key_pos++;
				if (key_pos >= span)
					key_pos = 0;
			end
			nbits = last ? (hbd_pkg::BYTE_BITS - int'(pad)) % hbd_pkg::BYTE_BITS
				: hbd_pkg::BYTE_BITS;
			for (int i = 0; i < nbits; i++) begin
				bit_v = b[7 - i];
				cur   = tree[walk_idx];
				has   = bit_v ? cur.has_right : cur.has_left;
				if (!has) begin
					in_error = 1'b1;
					push_out(hbd_pkg::KIND_STATUS, 8'd0, hbd_pkg::ST_MISSING);
					due[due.size() - 1].last = 1'b1;
					if (last)
						end_stream();
					return;
				end
				child = bit_v ? cur.right : cur.left;
				nxt   = tree[child];
				if (!nxt.has_left && !nxt.has_right) begin
					push_out(hbd_pkg::KIND_SYMBOL, nxt.symbol, hbd_pkg::ST_OK);
					walk_idx = root_idx;
				end else begin
					walk_idx = child;
				end
			end
			if (last) begin
				push_out(hbd_pkg::KIND_STATUS, 8'd0,
					(walk_idx == root_idx) ? hbd_pkg::ST_OK : hbd_pkg::ST_MIDCODE);
				end_stream();
			end
			if (due.size() > first)
				due[due.size() - 1].last = 1'b1;
		endfunction

		function void absorb_item(req_item_t it);
			hbd_pkg::node_t entry;
			case (it.req)
				hbd_pkg::REQ_NODE: begin
					entry.left      = it.left_child;
					entry.right     = it.right_child;
					entry.has_left  = it.has_left;
					entry.has_right = it.has_right;
					entry.symbol    = it.node_symbol;
					tree[it.node_index] = entry;
				end
				hbd_pkg::REQ_KEY:  key_bytes[it.key_index] = it.key_value;
				hbd_pkg::REQ_DATA: walk_byte(it.data_byte, it.last_byte);
				default: ;
			endcase
		endfunction

		function void check_output(hbd_pkg::kind_t k, logic [7:0] s, hbd_pkg::status_t st,
				logic l);
			dec_out_t e;
			if (due.size() == 0) begin
				fails++;
				if (fails <= REPORT_LIMIT)
					$display("%0t: unexpected result: kind %0d symbol %02h status %0d last %0d",
						$time, k, s, st, l);
				return;
			end
			e = due.pop_front();
			if (e.kind !== k || e.symbol !== s || e.status !== st || e.last !== l) begin
				fails++;
				if (fails <= REPORT_LIMIT)
					$display("%0t: mismatch: expected %0d %02h %0d %0d, got %0d %02h %0d %0d",
						$time, e.kind, e.symbol, e.status, e.last, k, s, st, l);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;

	decode_checker chk;

	// Stimulus bookkeeping: which table entries hold data, so the walk never
	// reads a node or key that was never loaded.
	bit node_loaded [NODES];
	int loaded_list [$];
	bit key_loaded [KEYS];
	int items_sent;
	int cycles;
	bit in_calm;    // no gaps on the input side for this phase
	bit out_calm;   // result side always ready for this phase

	huffman_tree_bit_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int idle_cycles(bit calm);
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	// every field random; callers overwrite the ones that matter
	function automatic req_item_t random_item(logic [1:0] req);
		req_item_t it;
		it.req         = req;
		it.node_index  = 9'($urandom);
		it.left_child  = 9'($urandom);
		it.right_child = 9'($urandom);
		it.has_left    = 1'($urandom);
		it.has_right   = 1'($urandom);
		it.node_symbol = 8'($urandom);
		it.key_index   = 6'($urandom);
		it.key_value   = 8'($urandom);
		it.data_byte   = 8'($urandom);
		it.last_byte   = 1'($urandom);
		return it;
	endfunction

	function automatic int key_prefix();
		int n;
		n = 0;
		while (n < KEYS && key_loaded[n])
			n++;
		return n;
	endfunction

	// Valid stays high straight into the next item when no gap is drawn.
	task automatic send_item(req_item_t it);
		int gap;
		gap = idle_cycles(in_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'd0, it.data_byte, it.key_value, it.key_index, it.node_symbol,
			it.has_right, it.has_left, it.right_child, it.left_child, it.node_index};
		s_axis_tuser  <= it.req;
		s_axis_tlast  <= it.last_byte;
		do @(posedge clk); while (!s_axis_tready);
		if (it.req != REQ_UNUSED)
			items_sent++;
	endtask

	task automatic load_node(logic [8:0] idx, logic [8:0] l, logic [8:0] r,
			logic hl, logic hr, logic [7:0] sym);
		req_item_t it;
		it = random_item(hbd_pkg::REQ_NODE);
		it.node_index  = idx;
		it.left_child  = l;
		it.right_child = r;
		it.has_left    = hl;
		it.has_right   = hr;
		it.node_symbol = sym;
		send_item(it);
		if (!node_loaded[idx]) begin
			node_loaded[idx] = 1'b1;
			loaded_list.push_back(int'(idx));
		end
	endtask

	task automatic load_key(int idx, logic [7:0] value);
		req_item_t it;
		it = random_item(hbd_pkg::REQ_KEY);
		it.key_index = 6'(idx);
		it.key_value = value;
		send_item(it);
		key_loaded[idx] = 1'b1;
	endtask

	task automatic send_byte(logic [7:0] b, logic last);
		req_item_t it;
		it = random_item(hbd_pkg::REQ_DATA);
		it.data_byte = b;
		it.last_byte = last;
		send_item(it);
	endtask

	// Builds a random tree bottom-up: leaves first, then parents that pair two
	// subtrees, so a child is always loaded before anything points at it.
	// drop_pct gives the chance that an internal node loses one child.
	task automatic make_tree(int leaves, int drop_pct, output logic [8:0] root_out);
		bit   taken [NODES];
		int   subtrees [$];
		int   a;
		int   b;
		int   pos;
		int   idx;
		logic hl;
		logic hr;
		foreach (taken[i])
			taken[i] = 1'b0;
		for (int k = 0; k < leaves; k++) begin
			do idx = $urandom_range(0, NODES - 1); while (taken[idx]);
			taken[idx] = 1'b1;
			load_node(9'(idx), 9'($urandom), 9'($urandom), 1'b0, 1'b0, 8'($urandom));
			subtrees.push_back(idx);
		end
		while (subtrees.size() > 1) begin
			pos = $urandom_range(0, subtrees.size() - 1);
			a   = subtrees[pos];
			subtrees.delete(pos);
			pos = $urandom_range(0, subtrees.size() - 1);
			b   = subtrees[pos];
			subtrees.delete(pos);
			do idx = $urandom_range(0, NODES - 1); while (taken[idx]);
			taken[idx] = 1'b1;
			hl = 1'b1;
			hr = 1'b1;
			if ($urandom_range(0, 99) < drop_pct) begin
				if ($urandom_range(0, 1) == 1)
					hl = 1'b0;
				else
					hr = 1'b0;
			end
			load_node(9'(idx), 9'(a), 9'(b), hl, hr, 8'($urandom));
			subtrees.push_back(idx);
		end
		root_out = 9'(subtrees[0]);
	endtask

	task automatic write_reg(hbd_pkg::cfg_reg_t idx, logic [8:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Registers change only with the block idle: all owed results in, then a
	// quiet spell for bytes swallowed after an error that give no result.
	task automatic set_regs(logic [8:0] root, logic [6:0] klen, logic [2:0] pad);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (chk.outstanding() != 0);
		repeat (SETTLE) @(posedge clk);
		write_reg(hbd_pkg::CFG_ROOT, root);
		write_reg(hbd_pkg::CFG_KEYLEN, 9'(klen));
		write_reg(hbd_pkg::CFG_PAD, 9'(pad));
		cfg_valid <= 1'b0;
	endtask

	// Off-stream traffic: stray loads, ignored requests and broken streams.
	task automatic noise_item();
		req_item_t it;
		logic [8:0] l;
		logic [8:0] r;
		logic       hl;
		logic       hr;
		case ($urandom_range(0, 4))
			0: begin
				hl = 1'($urandom);
				hr = 1'($urandom);
				l  = hl ? 9'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]) :
					9'($urandom);
				r  = hr ? 9'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]) :
					9'($urandom);
				load_node(9'($urandom), l, r, hl, hr, 8'($urandom));
			end
			1: load_key($urandom_range(0, KEYS - 1), 8'($urandom));
			2: begin
				it = random_item(REQ_UNUSED);
				send_item(it);
			end
			3: send_byte(8'($urandom), 1'($urandom));
			default: send_byte(8'($urandom), 1'b1);
		endcase
	endtask

	// Result side: ready drops for a freshly drawn gap before each transfer, unless the phase is calm.
	initial begin
		int gap;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		forever begin
			gap = idle_cycles(out_calm);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Monitor: every accepted transfer is taken from the pins, so the
	// prediction follows exactly what the block saw.
	always @(posedge clk) begin : bus_monitor
		req_item_t seen;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				chk.write_reg(hbd_pkg::cfg_reg_t'(cfg_index), cfg_data);
			if (s_axis_tvalid && s_axis_tready) begin
				seen.req         = s_axis_tuser;
				seen.node_index  = s_axis_tdata[8:0];
				seen.left_child  = s_axis_tdata[17:9];
				seen.right_child = s_axis_tdata[26:18];
				seen.has_left    = s_axis_tdata[27];
				seen.has_right   = s_axis_tdata[28];
				seen.node_symbol = s_axis_tdata[36:29];
				seen.key_index   = s_axis_tdata[42:37];
				seen.key_value   = s_axis_tdata[50:43];
				seen.data_byte   = s_axis_tdata[58:51];
				seen.last_byte   = s_axis_tlast;
				chk.absorb_item(seen);
			end
			if (m_axis_tvalid && m_axis_tready)
				chk.check_output(hbd_pkg::kind_t'(m_axis_tuser), m_axis_tdata[7:0],
					hbd_pkg::status_t'(m_axis_tdata[9:8]), m_axis_tlast);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_huffman_tree_bit_decoder failed");
			$finish;
		end
	end

	initial begin
		logic [8:0] top;
		logic [8:0] root;
		logic [6:0] klen;
		logic [2:0] pad;
		int         span;
		int         phase;
		int         n;
		chk           = new();
		items_sent    = 0;
		cycles        = 0;
		in_calm       = 1'b0;
		out_calm      = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= hbd_pkg::REQ_NODE;
		s_axis_tlast  <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= hbd_pkg::CFG_ROOT;
		cfg_data      <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed opening ---
		// Two leaves under roots at both ends of the table: every bit is a symbol,
		// so a full byte gives eight results.
		load_node(9'd1, 9'd0, 9'd0, 1'b0, 1'b0, 8'h00);
		load_node(9'd2, 9'd511, 9'd511, 1'b0, 1'b0, 8'hFF);
		load_node(9'd511, 9'd1, 9'd2, 1'b1, 1'b1, 8'h5A);
		load_node(9'd0, 9'd2, 9'd1, 1'b1, 1'b1, 8'hA5);
		set_regs(9'd511, 7'd0, 3'd0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h3C, 1'b1);     // pad 0: no bit of the last byte is walked

		// deeper tree, one bit on the last byte: ends mid-code or on a leaf
		make_tree(3, 0, top);
		set_regs(top, 7'd0, 3'd7);
		send_byte(8'h00, 1'b1);

		// one-child node: the walk soon hits a missing child, then the stream
		// is swallowed up to and including the last byte
		make_tree(2, 100, top);
		set_regs(top, 7'd0, 3'd1);
		send_byte(8'h0F, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);

		// root that is itself a leaf
		load_node(9'd3, 9'd0, 9'd0, 1'b0, 1'b0, 8'h42);
		set_regs(9'd3, 7'd0, 3'd4);
		send_byte(8'h00, 1'b1);

		// key XOR over a short key, plus one random off-stream item
		load_key(0, 8'hFF);
		load_key(1, 8'h81);
		set_regs(9'd0, 7'd2, 3'd3);
		send_byte(8'h12, 1'b0);
		noise_item();
		send_byte(8'hED, 1'b1);

		// --- random body: mostly proper streams on fresh trees ---
		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			in_calm  = ($urandom_range(0, 3) == 0);
			out_calm = ($urandom_range(0, 3) == 0);
			if (phase == 0 || $urandom_range(0, 2) == 0)
				make_tree(($urandom_range(0, 5) == 0) ? $urandom_range(12, 24) :
					$urandom_range(2, 8), ($urandom_range(0, 3) == 0) ? 25 : 0, top);
			// the whole key table once, so the longest key can be used
			if (phase == 2)
				for (int k = 0; k < KEYS; k++)
					load_key(k, 8'($urandom));
			case ($urandom_range(0, 9))
				0: root = 9'd0;
				1: root = 9'd511;
				2: root = 9'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
				default: root = top;
			endcase
			span = key_prefix();
			case ($urandom_range(0, 3))
				0: klen = 7'd0;
				1: klen = 7'(span);
				default: klen = 7'($urandom_range(0, span));
			endcase
			case ($urandom_range(0, 3))
				0: pad = 3'd0;
				1: pad = 3'd7;
				default: pad = 3'($urandom);
			endcase
			set_regs(root, klen, pad);
			repeat ($urandom_range(1, 3)) begin
				n = $urandom_range(1, 6);
				for (int j = 0; j < n; j++) begin
					if ($urandom_range(0, 9) == 0)
						noise_item();
					send_byte(8'($urandom), j == n - 1);
				end
			end
			phase++;
		end

		// drain: all owed results, then a quiet spell for any stray transfer
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (chk.outstanding() != 0);
		repeat (SETTLE) @(posedge clk);
		if (chk.fails == 0)
			$display("tb_huffman_tree_bit_decoder passed");
		else
			$display("tb_huffman_tree_bit_decoder failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/hbd_pkg.sv
hdl/hbd_tree_ram.sv
hdl/hbd_key_ram.sv
hdl/hbd_walk_unit.sv
hdl/huffman_tree_bit_decoder.sv
bench/tb_huffman_tree_bit_decoder.sv
